// ===== rtl/mabt_pkg.sv =====
// Shared types, sizes and codes for the masked address block table.
`timescale 1ns / 1ps
`default_nettype none
package mabt_pkg;

  // Table sizing
  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int POS_W       = 7;
  localparam int USED_W      = 7;
  localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Command queue between front and back
  localparam int CMDQ_DEPTH  = 2;
  localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);

  // Opcodes
  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  // Result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [31:0]      client_address;
    logic [31:0]      block_address;
    logic [31:0]      block_mask;
    logic [31:0]      expiry_seconds;
    logic [POS_W-1:0] entry_position;
    logic [31:0]      now_seconds;
  } in_beat_t;

  typedef struct packed {
    logic              blocked;
    logic [1:0]        status;
    logic [USED_W-1:0] entries_used;
  } out_beat_t;

  // Classified command kinds
  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_LOOKUP,
    CMD_ADD,
    CMD_REMOVE,
    CMD_BAD_POS
  } cmd_kind_t;

  // key: client (lookup) or block address (add); stamp: now (lookup) or expiry (add)
  typedef struct packed {
    cmd_kind_t        kind;
    logic [31:0]      key;
    logic [31:0]      mask;
    logic [31:0]      stamp;
    logic [POS_W-1:0] pos;
  } cmd_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] mask;
    logic [31:0] expiry;
  } entry_t;

endpackage
`default_nettype wire

// ===== rtl/mabt_front.sv =====
// Front end: takes input beats and classifies them into queue commands.
`timescale 1ns / 1ps
`default_nettype none
module mabt_front (
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire mabt_pkg::in_beat_t in_data,
  input  wire logic              q_full,
  output logic                   push,
  output mabt_pkg::cmd_t         cmd
);

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  // Decode opcode, fold trivial cases into no-op / reject
  always_comb begin
    cmd.kind  = mabt_pkg::CMD_NOP;
    cmd.key   = in_data.client_address;
    cmd.mask  = in_data.block_mask;
    cmd.stamp = in_data.now_seconds;
    cmd.pos   = in_data.entry_position;
    case (in_data.opcode)
      mabt_pkg::OP_LOOKUP: begin
        // zero client never matches
        if (in_data.client_address != 32'd0) begin
          cmd.kind = mabt_pkg::CMD_LOOKUP;
        end
      end
      mabt_pkg::OP_ADD: begin
        cmd.kind  = mabt_pkg::CMD_ADD;
        cmd.key   = in_data.block_address;
        cmd.stamp = in_data.expiry_seconds;
      end
      mabt_pkg::OP_REMOVE: begin
        if (in_data.entry_position == '0) begin
          cmd.kind = mabt_pkg::CMD_BAD_POS;
        end else begin
          cmd.kind = mabt_pkg::CMD_REMOVE;
        end
      end
      default: begin
        cmd.kind = mabt_pkg::CMD_NOP;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/mabt_cmd_fifo.sv =====
// Short command queue between the front end and the table engine.
`timescale 1ns / 1ps
`default_nettype none
module mabt_cmd_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire mabt_pkg::cmd_t push_data,
  input  wire logic           pop,
  output mabt_pkg::cmd_t      head,
  output logic                full,
  output logic                empty
);

  mabt_pkg::cmd_t                   slots [mabt_pkg::CMDQ_DEPTH];
  logic [mabt_pkg::CMDQ_PTR_W-1:0]  wr_ptr;
  logic [mabt_pkg::CMDQ_PTR_W-1:0]  rd_ptr;
  logic [mabt_pkg::CMDQ_CNT_W-1:0]  fill;

  localparam logic [mabt_pkg::CMDQ_PTR_W-1:0] LAST_PTR =
    mabt_pkg::CMDQ_PTR_W'(mabt_pkg::CMDQ_DEPTH - 1);
  localparam logic [mabt_pkg::CMDQ_CNT_W-1:0] FULL_CNT =
    mabt_pkg::CMDQ_CNT_W'(mabt_pkg::CMDQ_DEPTH);

  assign head  = slots[rd_ptr];
  assign full  = (fill == FULL_CNT);
  assign empty = (fill == '0);

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mabt_engine.sv =====
// Back end: table memory, sequential scan / shift engine and result register.
`timescale 1ns / 1ps
`default_nettype none
module mabt_engine (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire mabt_pkg::cmd_t q_head,
  input  wire logic           q_empty,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output mabt_pkg::out_beat_t out_data
);

  typedef enum logic {ST_IDLE, ST_SCAN} state_t;

  localparam logic [mabt_pkg::CNT_W-1:0] FULL_COUNT =
    mabt_pkg::CNT_W'(mabt_pkg::TABLE_DEPTH);

  // Table memory
  mabt_pkg::entry_t                mem [mabt_pkg::TABLE_DEPTH];
  mabt_pkg::entry_t                mem_q;
  logic                            mem_re;
  logic [mabt_pkg::IDX_W-1:0]      mem_raddr;
  logic                            mem_we;
  logic [mabt_pkg::IDX_W-1:0]      mem_waddr;
  mabt_pkg::entry_t                mem_wdata;

  // FSM registers
  state_t                          state, state_next;
  mabt_pkg::cmd_t                  cmd, cmd_next;
  logic [mabt_pkg::CNT_W-1:0]      count, count_next;
  logic [mabt_pkg::CNT_W-1:0]      rd_idx, rd_idx_next;
  logic [mabt_pkg::IDX_W-1:0]      chk_idx, chk_idx_next;
  logic                            pend, pend_next;
  logic                            res_valid, res_valid_next;
  mabt_pkg::out_beat_t             res, res_next;

  logic                            lookup_match;
  logic                            add_match;
  logic                            scan_hit;
  logic                            scan_more;

  assign out_valid = res_valid;
  assign out_data  = res;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= mem[mem_raddr];
    end
  end

  // Compare the entry read last cycle against the current command
  assign lookup_match = ((mem_q.addr & mem_q.mask) == (cmd.key & mem_q.mask)) &&
                        ((mem_q.expiry == 32'd0) || (cmd.stamp < mem_q.expiry));
  assign add_match    = (mem_q.addr == cmd.key) && (mem_q.mask == cmd.mask);
  assign scan_hit     = pend && (((cmd.kind == mabt_pkg::CMD_LOOKUP) && lookup_match) ||
                                 ((cmd.kind == mabt_pkg::CMD_ADD) && add_match));
  assign scan_more    = (rd_idx < count);

  // Next-state logic
  always_comb begin
    state_next     = state;
    cmd_next       = cmd;
    count_next     = count;
    rd_idx_next    = rd_idx;
    chk_idx_next   = chk_idx;
    pend_next      = pend;
    res_valid_next = res_valid && !out_ready;
    res_next       = res;
    pop            = 1'b0;
    mem_re         = 1'b0;
    mem_raddr      = rd_idx[mabt_pkg::IDX_W-1:0];
    mem_we         = 1'b0;
    mem_waddr      = chk_idx;
    mem_wdata      = '{addr: cmd.key, mask: cmd.mask, expiry: cmd.stamp};

    case (state)
      ST_IDLE: begin
        // start a command only when the result slot is free
        if (!q_empty && !res_valid) begin
          pop         = 1'b1;
          cmd_next    = q_head;
          rd_idx_next = '0;
          pend_next   = 1'b0;
          res_next    = '{blocked: 1'b0, status: mabt_pkg::STATUS_OK,
                          entries_used: mabt_pkg::USED_W'(count)};
          case (q_head.kind)
            mabt_pkg::CMD_LOOKUP, mabt_pkg::CMD_ADD: begin
              state_next = ST_SCAN;
            end
            mabt_pkg::CMD_REMOVE: begin
              if (mabt_pkg::CMP_W'(q_head.pos) > mabt_pkg::CMP_W'(count)) begin
                res_next.status = mabt_pkg::STATUS_NOT_FOUND;
                res_valid_next  = 1'b1;
              end else begin
                // shift starts by reading the entry after the removed one
                rd_idx_next = mabt_pkg::CNT_W'(q_head.pos);
                state_next  = ST_SCAN;
              end
            end
            mabt_pkg::CMD_BAD_POS: begin
              res_next.status = mabt_pkg::STATUS_NOT_FOUND;
              res_valid_next  = 1'b1;
            end
            default: begin
              res_valid_next = 1'b1;
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (scan_hit) begin
          // lookup hit, or add of an existing pair: refresh expiry
          if (cmd.kind == mabt_pkg::CMD_ADD) begin
            mem_we    = 1'b1;
            mem_waddr = chk_idx;
          end
          res_next.blocked = (cmd.kind == mabt_pkg::CMD_LOOKUP);
          res_next.status  = mabt_pkg::STATUS_OK;
          res_valid_next   = 1'b1;
          pend_next        = 1'b0;
          state_next       = ST_IDLE;
        end else if (!pend && !scan_more) begin
          // scan finished without a hit
          res_next.blocked = 1'b0;
          res_next.status  = mabt_pkg::STATUS_OK;
          case (cmd.kind)
            mabt_pkg::CMD_ADD: begin
              if (count == FULL_COUNT) begin
                res_next.status = mabt_pkg::STATUS_FULL;
              end else begin
                mem_we                = 1'b1;
                mem_waddr             = count[mabt_pkg::IDX_W-1:0];
                count_next            = count + 1'b1;
                res_next.entries_used = mabt_pkg::USED_W'(count + 1'b1);
              end
            end
            mabt_pkg::CMD_REMOVE: begin
              count_next            = count - 1'b1;
              res_next.entries_used = mabt_pkg::USED_W'(count - 1'b1);
            end
            default: begin
              res_next.blocked = 1'b0;
            end
          endcase
          res_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end else begin
          // remove: move the entry read last cycle up one place
          if (pend && (cmd.kind == mabt_pkg::CMD_REMOVE)) begin
            mem_we    = 1'b1;
            mem_waddr = chk_idx - 1'b1;
            mem_wdata = mem_q;
          end
          if (scan_more) begin
            mem_re       = 1'b1;
            rd_idx_next  = rd_idx + 1'b1;
            chk_idx_next = rd_idx[mabt_pkg::IDX_W-1:0];
            pend_next    = 1'b1;
          end else begin
            pend_next = 1'b0;
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    cmd     <= cmd_next;
    rd_idx  <= rd_idx_next;
    chk_idx <= chk_idx_next;
    res     <= res_next;
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      pend      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      pend      <= pend_next;
      res_valid <= res_valid_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/masked_address_block_table.sv =====
// Lookup and add scan the entries held when the engine starts the beat, stopping at a hit;
// one table entry is read per cycle. Remove moves each entry after the removed position up
// one place. Unused opcode, zero client and a bad position are answered without a scan.
// Throughput: one beat at a time in the engine, the next starting the cycle after the result
// beat is taken; the queue holds two more. Reset: table empty, memory contents not cleared.
`timescale 1ns / 1ps
`default_nettype none
module masked_address_block_table (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire mabt_pkg::in_beat_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output mabt_pkg::out_beat_t      out_data
);

  mabt_pkg::cmd_t front_cmd;
  mabt_pkg::cmd_t q_head;
  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_empty;

  // Accept and classify
  mabt_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .cmd      (front_cmd)
  );

  // Command queue
  mabt_cmd_fifo u_cmd_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (front_cmd),
    .pop       (pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Table engine
  mabt_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== tb/tb_masked_address_block_table.sv =====
// Testbench for the masked address block table: directed rows, random commands, predictor check.
`timescale 1ns / 1ps
module tb_masked_address_block_table;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         RANDOM_CMDS = 1200;
  localparam int         CYCLE_LIMIT = 500000;
  localparam int         HOLD_AT     = 300;
  localparam int         HOLD_CYCLES = 400;

  typedef struct {
    mabt_pkg::in_beat_t  beat;
    bit                  fixed_answer;
    mabt_pkg::out_beat_t answer;
  } stim_row_t;

  logic                clk;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  mabt_pkg::in_beat_t  in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  mabt_pkg::out_beat_t out_data;

  // Predictor copy of the table
  logic [31:0] tbl_addr   [mabt_pkg::TABLE_DEPTH];
  logic [31:0] tbl_mask   [mabt_pkg::TABLE_DEPTH];
  logic [31:0] tbl_expiry [mabt_pkg::TABLE_DEPTH];
  int          tbl_count = 0;

  mabt_pkg::out_beat_t awaited_answers [$];
  stim_row_t           directed_rows [$];
  int                  mismatches = 0;
  int                  cycles = 0;

  masked_address_block_table dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

  // Run watchdog
  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // Append to the tail of the directed table
  function automatic void add_row(input stim_row_t row);
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  // Append to the tail of the expected-beat queue
  function automatic void await_answer(input mabt_pkg::out_beat_t a);
    awaited_answers.insert(awaited_answers.size(), a);
  endfunction

  // Idle draw, with every fourth stretch of 100 beats running back to back
  function automatic int idle_cycles(input int n);
    if ((n / 100) % 4 == 3) return 0;
    return $urandom_range(0, 5);
  endfunction

  // Expected answer for one command; updates the predictor table
  function automatic mabt_pkg::out_beat_t predict_response(input mabt_pkg::in_beat_t b);
    mabt_pkg::out_beat_t r;
    bit                  hit;
    int                  i;
    r = '0;
    hit = 1'b0;
    case (b.opcode)
      mabt_pkg::OP_LOOKUP: begin
        if (b.client_address != 32'd0) begin
          for (i = 0; i < tbl_count; i++) begin
            if (((tbl_addr[i] ^ b.client_address) & tbl_mask[i]) == 32'd0 &&
                (tbl_expiry[i] == 32'd0 || b.now_seconds < tbl_expiry[i]))
              r.blocked = 1'b1;
          end
        end
      end
      mabt_pkg::OP_ADD: begin
        for (i = 0; i < tbl_count; i++) begin
          if (tbl_addr[i] == b.block_address && tbl_mask[i] == b.block_mask) begin
            tbl_expiry[i] = b.expiry_seconds;
            hit = 1'b1;
          end
        end
        if (!hit) begin
          if (tbl_count >= mabt_pkg::TABLE_DEPTH) begin
            r.status = mabt_pkg::STATUS_FULL;
          end else begin
            tbl_addr[tbl_count]   = b.block_address;
            tbl_mask[tbl_count]   = b.block_mask;
            tbl_expiry[tbl_count] = b.expiry_seconds;
            tbl_count++;
          end
        end
      end
      mabt_pkg::OP_REMOVE: begin
        if (b.entry_position == '0 || int'(b.entry_position) > tbl_count) begin
          r.status = mabt_pkg::STATUS_NOT_FOUND;
        end else begin
          // later entries move up one place
          for (i = int'(b.entry_position) - 1; i + 1 < tbl_count; i++) begin
            tbl_addr[i]   = tbl_addr[i + 1];
            tbl_mask[i]   = tbl_mask[i + 1];
            tbl_expiry[i] = tbl_expiry[i + 1];
          end
          tbl_count--;
        end
      end
      default: ;
    endcase
    r.entries_used = mabt_pkg::USED_W'(tbl_count);
    return r;
  endfunction

  // Directed row: a/b/c are client/now for lookup, address/mask/expiry for add
  function automatic stim_row_t stim_row(input logic [1:0] op, input logic [31:0] a,
                                         input logic [31:0] b, input logic [31:0] c,
                                         input int pos, input int fixed, input int blk,
                                         input logic [1:0] st, input int used);
    stim_row_t r;
    r.beat.opcode         = op;
    r.beat.client_address = (op == mabt_pkg::OP_LOOKUP) ? a : $urandom;
    r.beat.now_seconds    = (op == mabt_pkg::OP_LOOKUP) ? b : $urandom;
    r.beat.block_address  = (op == mabt_pkg::OP_ADD) ? a : $urandom;
    r.beat.block_mask     = (op == mabt_pkg::OP_ADD) ? b : $urandom;
    r.beat.expiry_seconds = (op == mabt_pkg::OP_ADD) ? c : $urandom;
    r.beat.entry_position = (op == mabt_pkg::OP_REMOVE) ? mabt_pkg::POS_W'(pos)
                                                        : mabt_pkg::POS_W'($urandom_range(0, 127));
    r.fixed_answer        = (fixed != 0);
    r.answer.blocked      = (blk != 0);
    r.answer.status       = st;
    r.answer.entries_used = mabt_pkg::USED_W'(used);
    return r;
  endfunction

  function automatic logic [31:0] prefix_mask();
    int len;
    len = $urandom_range(0, 32);
    if ($urandom_range(0, 9) == 0) return $urandom;
    return (len == 0) ? 32'd0 : (32'hFFFF_FFFF << (32 - len));
  endfunction

  function automatic logic [31:0] pick_time();
    if ($urandom_range(0, 1) == 0) return $urandom_range(0, 2000);
    return $urandom;
  endfunction

  // Random command; phases favor filling, mixing or draining the table
  function automatic mabt_pkg::in_beat_t random_command(input int n);
    mabt_pkg::in_beat_t b;
    int                 r;
    int                 k;
    int                 mode;
    b.opcode         = OP_UNUSED;
    b.client_address = $urandom;
    b.block_address  = $urandom;
    b.block_mask     = $urandom;
    b.expiry_seconds = $urandom;
    b.entry_position = mabt_pkg::POS_W'($urandom_range(0, 127));
    b.now_seconds    = $urandom;
    mode = (n / 150) % 3;
    r = $urandom_range(0, 99);
    if (mode == 0)
      b.opcode = (r < 65) ? mabt_pkg::OP_ADD : (r < 90) ? mabt_pkg::OP_LOOKUP :
                 (r < 98) ? mabt_pkg::OP_REMOVE : OP_UNUSED;
    else if (mode == 1)
      b.opcode = (r < 30) ? mabt_pkg::OP_ADD : (r < 70) ? mabt_pkg::OP_LOOKUP :
                 (r < 95) ? mabt_pkg::OP_REMOVE : OP_UNUSED;
    else
      b.opcode = (r < 15) ? mabt_pkg::OP_ADD : (r < 45) ? mabt_pkg::OP_LOOKUP :
                 (r < 98) ? mabt_pkg::OP_REMOVE : OP_UNUSED;
    r = $urandom_range(0, 99);
    case (b.opcode)
      mabt_pkg::OP_LOOKUP: begin
        b.now_seconds = pick_time();
        if (r < 5) begin
          b.client_address = 32'd0;
        end else if (r < 65 && tbl_count > 0) begin
          k = $urandom_range(0, tbl_count - 1);
          b.client_address = (tbl_addr[k] & tbl_mask[k]) | ($urandom & ~tbl_mask[k]);
        end
      end
      mabt_pkg::OP_ADD: begin
        r = $urandom_range(0, 9);
        b.expiry_seconds = (r < 2) ? 32'd0 : pick_time();
        if ($urandom_range(0, 3) == 0 && tbl_count > 0) begin
          // refresh the expiry of a stored pair
          k = $urandom_range(0, tbl_count - 1);
          b.block_address = tbl_addr[k];
          b.block_mask    = tbl_mask[k];
        end else begin
          b.block_mask = prefix_mask();
        end
      end
      mabt_pkg::OP_REMOVE: begin
        if (r < 75 && tbl_count > 0)
          b.entry_position = mabt_pkg::POS_W'($urandom_range(1, tbl_count));
        else if (r < 85)
          b.entry_position = '0;
        else if (r < 92)
          b.entry_position = mabt_pkg::POS_W'(tbl_count + 1);
      end
      default: ;
    endcase
    return b;
  endfunction

  // Offer one beat after an idle gap; returns on the accepting edge
  task automatic offer_beat(input mabt_pkg::in_beat_t b, input int n);
    int gap;
    gap = idle_cycles(n);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  // Sender, prediction and end of run
  initial begin
    mabt_pkg::in_beat_t  beat;
    mabt_pkg::out_beat_t predicted;
    int                  n;
    n = 0;
    add_row(stim_row(mabt_pkg::OP_LOOKUP, 32'd0, 32'd0, 32'd0, 0, 1, 0,
                     mabt_pkg::STATUS_OK, 0));
    add_row(stim_row(mabt_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 0, 1, 0,
                     mabt_pkg::STATUS_OK, 0));
    add_row(stim_row(mabt_pkg::OP_REMOVE, 0, 0, 0, 0, 1, 0, mabt_pkg::STATUS_NOT_FOUND, 0));
    add_row(stim_row(mabt_pkg::OP_REMOVE, 0, 0, 0, 1, 1, 0, mabt_pkg::STATUS_NOT_FOUND, 0));
    add_row(stim_row(OP_UNUSED, 0, 0, 0, 1, 1, 0, mabt_pkg::STATUS_OK, 0));
    add_row(stim_row(mabt_pkg::OP_ADD, 32'hC0A8_0100, 32'hFFFF_FF00, 32'd0, 0, 1, 0,
                     mabt_pkg::STATUS_OK, 1));
    // permanent entry holds at the latest time
    add_row(stim_row(mabt_pkg::OP_LOOKUP, 32'hC0A8_01FF, 32'hFFFF_FFFF, 0, 0, 1, 1,
                     mabt_pkg::STATUS_OK, 1));
    add_row(stim_row(mabt_pkg::OP_LOOKUP, 32'hC0A9_0100, 32'd0, 0, 0, 1, 0,
                     mabt_pkg::STATUS_OK, 1));
    // mask zero matches every nonzero client
    add_row(stim_row(mabt_pkg::OP_ADD, 32'd0, 32'd0, 32'd1000, 0, 1, 0,
                     mabt_pkg::STATUS_OK, 2));
    add_row(stim_row(mabt_pkg::OP_LOOKUP, 32'h1234_5678, 32'd999, 0, 0, 1, 1,
                     mabt_pkg::STATUS_OK, 2));
    add_row(stim_row(mabt_pkg::OP_LOOKUP, 32'h1234_5678, 32'd1000, 0, 0, 1, 0,
                     mabt_pkg::STATUS_OK, 2));
    // same pair again only refreshes the expiry
    add_row(stim_row(mabt_pkg::OP_ADD, 32'd0, 32'd0, 32'hFFFF_FFFF, 0, 1, 0,
                     mabt_pkg::STATUS_OK, 2));
    add_row(stim_row(mabt_pkg::OP_LOOKUP, 32'h1234_5678, 32'hFFFF_FFFE, 0, 0, 1, 1,
                     mabt_pkg::STATUS_OK, 2));
    // zero client stays unblocked even against mask zero
    add_row(stim_row(mabt_pkg::OP_LOOKUP, 32'd0, 32'd0, 0, 0, 1, 0, mabt_pkg::STATUS_OK, 2));
    add_row(stim_row(mabt_pkg::OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd5, 0, 1, 0,
                     mabt_pkg::STATUS_OK, 3));
    add_row(stim_row(OP_UNUSED, 0, 0, 0, 1, 1, 0, mabt_pkg::STATUS_OK, 3));
    // position one past the end, and the largest position
    add_row(stim_row(mabt_pkg::OP_REMOVE, 0, 0, 0, 4, 1, 0, mabt_pkg::STATUS_NOT_FOUND, 3));
    add_row(stim_row(mabt_pkg::OP_REMOVE, 0, 0, 0, 127, 1, 0, mabt_pkg::STATUS_NOT_FOUND, 3));
    add_row(stim_row(mabt_pkg::OP_REMOVE, 0, 0, 0, 2, 1, 0, mabt_pkg::STATUS_OK, 2));
    add_row(stim_row(mabt_pkg::OP_LOOKUP, 32'h1234_5678, 32'd0, 0, 0, 0, 0,
                     mabt_pkg::STATUS_OK, 0));
    add_row(stim_row(mabt_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'd4, 0, 0, 0, 0,
                     mabt_pkg::STATUS_OK, 0));
    add_row(stim_row(mabt_pkg::OP_ADD, 32'hC0A8_0100, 32'hFFFF_FF00, 32'd7, 0, 0, 0,
                     mabt_pkg::STATUS_OK, 0));
    add_row(stim_row(mabt_pkg::OP_LOOKUP, 32'hC0A8_0101, 32'd7, 0, 0, 0, 0,
                     mabt_pkg::STATUS_OK, 0));
    add_row(stim_row(mabt_pkg::OP_REMOVE, 0, 0, 0, 1, 1, 0, mabt_pkg::STATUS_OK, 1));
    add_row(stim_row(mabt_pkg::OP_REMOVE, 0, 0, 0, 1, 1, 0, mabt_pkg::STATUS_OK, 0));

    do @(posedge clk); while (rst);

    // directed part
    foreach (directed_rows[i]) begin
      offer_beat(directed_rows[i].beat, n);
      predicted = predict_response(directed_rows[i].beat);
      await_answer(directed_rows[i].fixed_answer ? directed_rows[i].answer : predicted);
      n++;
    end

    // random part
    repeat (RANDOM_CMDS) begin
      beat = random_command(n);
      offer_beat(beat, n);
      await_answer(predict_response(beat));
      n++;
    end
    in_valid <= 1'b0;

    while (awaited_answers.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Receiver: random stalls, one long hold-off, field checks
  initial begin
    mabt_pkg::out_beat_t want;
    int                  seen;
    int                  hold;
    seen = 0;
    do @(posedge clk); while (rst);
    forever begin
      hold = (seen == HOLD_AT) ? HOLD_CYCLES : idle_cycles(seen);
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      seen++;
      if (awaited_answers.size() == 0) begin
        report_mismatch($sformatf("beat %0d arrived with nothing awaited", seen));
      end else begin
        want = awaited_answers.pop_front();
        if (out_data.blocked !== want.blocked)
          report_mismatch($sformatf("beat %0d blocked %b, want %b", seen,
                                    out_data.blocked, want.blocked));
        if (out_data.status !== want.status)
          report_mismatch($sformatf("beat %0d status %0d, want %0d", seen,
                                    out_data.status, want.status));
        if (out_data.entries_used !== want.entries_used)
          report_mismatch($sformatf("beat %0d entries_used %0d, want %0d", seen,
                                    out_data.entries_used, want.entries_used));
      end
    end
  end

endmodule
